// ----- design/pn3o_pkg.sv -----
// ----------------------------------------------------------------------------
// pn3o_pkg: shared types and constants for the 3D octave Perlin noise block
// Fixed-point formats, command/status structs, register indexes, codes.
// ----------------------------------------------------------------------------
package pn3o_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TBL_AW    = 8;
    localparam int TBL_DEPTH = 1 << TBL_AW;
    localparam int TBL_W     = 8;
    localparam int POS_W     = 32;

    localparam int F_W   = FRAC_BITS + 1;    // fade value, 0..ONE
    localparam int G_W   = FRAC_BITS + 3;    // gradient and lerp values
    localparam int Q_W   = FRAC_BITS + 5;    // fade polynomial term
    localparam int AMP_W = 17;               // octave weight, Q1.16 up to 1.0
    localparam int AMP_FRAC = 16;
    localparam int MA_W  = 21;               // multiplier operand A
    localparam int MB_W  = 18;               // multiplier operand B
    localparam int MP_W  = MA_W + MB_W;
    localparam int OUT_W = 18;
    localparam int CFG_W = 17;
    localparam int CNT_W = 4;

    localparam logic [AMP_W-1:0] AMP_ONE  = AMP_W'(1) << AMP_FRAC;
    localparam logic [F_W-1:0]   FADE_ONE = F_W'(1) << FRAC_BITS;
    localparam logic [Q_W-1:0]   Q_TEN    = Q_W'(10) << FRAC_BITS;
    localparam logic signed [G_W-1:0] G_ONE = G_W'(1) << FRAC_BITS;

    // configuration register indexes
    localparam logic REG_OCTAVE_COUNT = 1'b0;
    localparam logic REG_PERSISTENCE  = 1'b1;

    // input opcodes
    localparam logic OPC_WRITE = 1'b0;
    localparam logic OPC_EVAL  = 1'b1;

    // per-octave microsequence step boundaries
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] STEP_HASH    = 6'd12;
    localparam logic [STEP_W-1:0] STEP_GRAD    = 6'd24;
    localparam logic [STEP_W-1:0] STEP_GRAD_HI = 6'd38;
    localparam logic [STEP_W-1:0] STEP_ACC     = 6'd54;
    localparam logic [STEP_W-1:0] STEP_ACC_ADD = 6'd55;
    localparam logic [STEP_W-1:0] STEP_LAST    = 6'd56;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_WRITE,
        OP_FADE_SQ,
        OP_FADE_CUBE,
        OP_FADE_Q,
        OP_FADE_END,
        OP_RD,
        OP_CAP,
        OP_LMUL,
        OP_LADD,
        OP_ACC_MUL,
        OP_ACC_ADD,
        OP_AMP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_EMIT
    } op_t;

    // table address selects; the corner ones are ordered {z,y,x}
    typedef logic [3:0] addr_sel_t;
    localparam addr_sel_t AS_CX  = 4'd0;
    localparam addr_sel_t AS_CX1 = 4'd1;
    localparam addr_sel_t AS_A   = 4'd2;
    localparam addr_sel_t AS_A1  = 4'd3;
    localparam addr_sel_t AS_B   = 4'd4;
    localparam addr_sel_t AS_B1  = 4'd5;
    localparam addr_sel_t AS_AA  = 4'd6;
    localparam addr_sel_t AS_BA  = 4'd7;
    localparam addr_sel_t AS_AB  = 4'd8;
    localparam addr_sel_t AS_BB  = 4'd9;
    localparam addr_sel_t AS_AA1 = 4'd10;
    localparam addr_sel_t AS_BA1 = 4'd11;
    localparam addr_sel_t AS_AB1 = 4'd12;
    localparam addr_sel_t AS_BB1 = 4'd13;

    typedef logic [1:0] axis_t;
    localparam axis_t AX_X = 2'd0;
    localparam axis_t AX_Y = 2'd1;
    localparam axis_t AX_Z = 2'd2;

    typedef struct packed {
        op_t       op;
        addr_sel_t addr;
        axis_t     sel;
        logic      dst;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

// ----- design/pn3o_ram.sv -----
// ----------------------------------------------------------------------------
// pn3o_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pn3o_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/pn3o_dp.sv -----
// ----------------------------------------------------------------------------
// pn3o_dp: noise datapath
// Permutation table, shared multiplier, lerp/gradient registers, octave
// accumulator, restoring divider and output register.
// ----------------------------------------------------------------------------
module pn3o_dp
    import pn3o_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic [111:0]          s_tdata,
    input  logic [CFG_W-1:0]      persistence,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [23:0]           m_tdata
);

    localparam int TOT_W = 35 + $clog2(MAX_OCTAVES);
    localparam int WS_W  = 17 + $clog2(MAX_OCTAVES);
    localparam int DC_W  = $clog2(TOT_W);

    logic [POS_W-1:0] px_reg, py_reg, pz_reg;
    logic [TBL_AW-1:0] tidx_reg;
    logic [TBL_W-1:0]  tval_reg;
    logic [AMP_W-1:0]  pers_reg, amp_reg;
    logic [WS_W-1:0]   wsum_reg;
    logic signed [TOT_W-1:0] total_reg;
    logic signed [MP_W-1:0]  mul_reg;
    logic [FRAC_BITS-1:0]    t2_reg;
    logic [F_W-1:0] fx_reg, fy_reg, fz_reg;
    logic [TBL_AW-1:0] a_reg, b_reg, aa_reg, ab_reg, ba_reg, bb_reg;
    logic signed [G_W-1:0] ga_reg, gb_reg, l0_reg, l1_reg, m0_reg, m1_reg, nv_reg;
    logic [TOT_W-1:0] dvd_reg;
    logic [WS_W-1:0]  rem_reg;
    logic             neg_reg;
    logic [DC_W-1:0]  dcnt_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [TBL_DEPTH-1:0] vld_reg;
    logic             vq_reg;
    logic [TBL_AW-1:0] raddr_q_reg;

    logic [TBL_AW-1:0] cx, cy, cz, rd_addr, rd_val;
    logic [TBL_W-1:0]  ram_q;
    logic [FRAC_BITS-1:0] tx, ty, tz, t_sel;
    logic [Q_W-1:0] q_val;
    logic [3:0] cj;
    logic [3:0] h;
    logic signed [G_W-1:0] ox, oy, oz, gu, gv, grad;
    logic signed [G_W-1:0] la, lb, lres;
    logic [F_W-1:0] lf;
    logic signed [G_W:0] ldiff, lsum;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic [MP_W-FRAC_BITS-1:0] fade_raw;
    logic [WS_W+1:0] trial;
    logic qbit;
    logic [OUT_W-1:0] sat_val;

    assign cx = px_reg[FRAC_BITS +: TBL_AW];
    assign cy = py_reg[FRAC_BITS +: TBL_AW];
    assign cz = pz_reg[FRAC_BITS +: TBL_AW];
    assign tx = px_reg[FRAC_BITS-1:0];
    assign ty = py_reg[FRAC_BITS-1:0];
    assign tz = pz_reg[FRAC_BITS-1:0];

    always_comb begin
        case (cmd.sel)
            AX_X: begin
                t_sel = tx; la = ga_reg; lb = gb_reg; lf = fx_reg;
            end
            AX_Y: begin
                t_sel = ty; la = l0_reg; lb = l1_reg; lf = fy_reg;
            end
            default: begin
                t_sel = tz; la = m0_reg; lb = m1_reg; lf = fz_reg;
            end
        endcase
    end

    // 6*t2 + 10 - 15*t, always positive
    assign q_val = Q_W'({t2_reg, 2'b00}) + Q_W'({t2_reg, 1'b0}) + Q_TEN
                 - (Q_W'({t_sel, 4'b0000}) - Q_W'(t_sel));

    always_comb begin
        case (cmd.addr)
            AS_CX:   rd_addr = cx;
            AS_CX1:  rd_addr = cx + 1'b1;
            AS_A:    rd_addr = a_reg;
            AS_A1:   rd_addr = a_reg + 1'b1;
            AS_B:    rd_addr = b_reg;
            AS_B1:   rd_addr = b_reg + 1'b1;
            AS_AA:   rd_addr = aa_reg;
            AS_BA:   rd_addr = ba_reg;
            AS_AB:   rd_addr = ab_reg;
            AS_BB:   rd_addr = bb_reg;
            AS_AA1:  rd_addr = aa_reg + 1'b1;
            AS_BA1:  rd_addr = ba_reg + 1'b1;
            AS_AB1:  rd_addr = ab_reg + 1'b1;
            AS_BB1:  rd_addr = bb_reg + 1'b1;
            default: rd_addr = cx;
        endcase
    end

    pn3o_ram #(
        .WIDTH (TBL_W),
        .DEPTH (TBL_DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (cmd.op == OP_WRITE),
        .waddr (tidx_reg),
        .wdata (tval_reg),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // entries never written read as identity
    assign rd_val = vq_reg ? ram_q : raddr_q_reg;

    // gradient for the corner encoded in the address select
    always_comb begin
        cj = cmd.addr - AS_AA;
        h  = rd_val[3:0];
        ox = $signed({3'b000, tx}) - (cj[0] ? G_ONE : '0);
        oy = $signed({3'b000, ty}) - (cj[1] ? G_ONE : '0);
        oz = $signed({3'b000, tz}) - (cj[2] ? G_ONE : '0);
        gu = (h < 4'd8) ? ox : oy;
        if (h < 4'd4) begin
            gv = oy;
        end else if (h == 4'd12 || h == 4'd14) begin
            gv = ox;
        end else begin
            gv = oz;
        end
        grad = (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
    end

    assign ldiff = (G_W+1)'(lb) - (G_W+1)'(la);
    assign lsum  = (G_W+1)'(la) + (G_W+1)'(mul_reg >>> FRAC_BITS);
    assign lres  = lsum[G_W-1:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_FADE_SQ: begin
                mul_a = $signed(MA_W'(t_sel));
                mul_b = $signed(MB_W'(t_sel));
            end
            OP_FADE_CUBE: begin
                mul_a = $signed(MA_W'(mul_reg[2*FRAC_BITS-1:FRAC_BITS]));
                mul_b = $signed(MB_W'(t_sel));
            end
            OP_FADE_Q: begin
                mul_a = $signed(q_val);
                mul_b = $signed(MB_W'(mul_reg[2*FRAC_BITS-1:FRAC_BITS]));
            end
            OP_LMUL: begin
                mul_a = MA_W'(ldiff);
                mul_b = $signed(MB_W'(lf));
            end
            OP_ACC_MUL: begin
                mul_a = MA_W'(nv_reg);
                mul_b = $signed(MB_W'(amp_reg));
            end
            OP_ACC_ADD: begin
                mul_a = $signed(MA_W'(amp_reg));
                mul_b = $signed(MB_W'(pers_reg));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign fade_raw = mul_reg[MP_W-1:FRAC_BITS];

    assign trial = {1'b0, rem_reg, dvd_reg[TOT_W-1]} - {2'b00, wsum_reg};
    assign qbit  = ~trial[WS_W+1];

    always_comb begin
        if (!neg_reg) begin
            sat_val = (dvd_reg > TOT_W'(131071)) ? 18'h1FFFF : dvd_reg[OUT_W-1:0];
        end else begin
            sat_val = (dvd_reg > TOT_W'(131072)) ? 18'h20000 : -dvd_reg[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LATCH: begin
                tidx_reg  <= s_tdata[7:0];
                tval_reg  <= s_tdata[15:8];
                px_reg    <= s_tdata[47:16];
                py_reg    <= s_tdata[79:48];
                pz_reg    <= s_tdata[111:80];
                pers_reg  <= (persistence > AMP_ONE) ? AMP_ONE : persistence;
                amp_reg   <= AMP_ONE;
                wsum_reg  <= '0;
                total_reg <= '0;
            end
            OP_FADE_CUBE: t2_reg <= mul_reg[2*FRAC_BITS-1:FRAC_BITS];
            OP_FADE_END: begin
                case (cmd.sel)
                    AX_X: fx_reg <= (fade_raw > (MP_W-FRAC_BITS)'(FADE_ONE)) ?
                                    FADE_ONE : fade_raw[F_W-1:0];
                    AX_Y: fy_reg <= (fade_raw > (MP_W-FRAC_BITS)'(FADE_ONE)) ?
                                    FADE_ONE : fade_raw[F_W-1:0];
                    default: fz_reg <= (fade_raw > (MP_W-FRAC_BITS)'(FADE_ONE)) ?
                                    FADE_ONE : fade_raw[F_W-1:0];
                endcase
            end
            OP_CAP: begin
                case (cmd.addr)
                    AS_CX:  a_reg  <= rd_val + cy;
                    AS_CX1: b_reg  <= rd_val + cy;
                    AS_A:   aa_reg <= rd_val + cz;
                    AS_A1:  ab_reg <= rd_val + cz;
                    AS_B:   ba_reg <= rd_val + cz;
                    AS_B1:  bb_reg <= rd_val + cz;
                    default: begin
                        if (cj[0]) begin
                            gb_reg <= grad;
                        end else begin
                            ga_reg <= grad;
                        end
                    end
                endcase
            end
            OP_LADD: begin
                case (cmd.sel)
                    AX_X: begin
                        if (cmd.dst) begin
                            l1_reg <= lres;
                        end else begin
                            l0_reg <= lres;
                        end
                    end
                    AX_Y: begin
                        if (cmd.dst) begin
                            m1_reg <= lres;
                        end else begin
                            m0_reg <= lres;
                        end
                    end
                    default: nv_reg <= lres;
                endcase
            end
            OP_ACC_MUL: wsum_reg <= wsum_reg + WS_W'(amp_reg);
            OP_ACC_ADD: total_reg <= total_reg + TOT_W'(mul_reg);
            OP_AMP: begin
                amp_reg <= mul_reg[AMP_FRAC +: AMP_W];
                px_reg  <= {px_reg[POS_W-2:0], 1'b0};
                py_reg  <= {py_reg[POS_W-2:0], 1'b0};
                pz_reg  <= {pz_reg[POS_W-2:0], 1'b0};
            end
            OP_DIV_INIT: begin
                neg_reg  <= total_reg[TOT_W-1];
                dvd_reg  <= total_reg[TOT_W-1] ? TOT_W'(-total_reg) : TOT_W'(total_reg);
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            OP_DIV_STEP: begin
                rem_reg  <= qbit ? trial[WS_W-1:0] : {rem_reg[WS_W-2:0], dvd_reg[TOT_W-1]};
                dvd_reg  <= {dvd_reg[TOT_W-2:0], qbit};
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            OP_EMIT: out_data_reg <= sat_val;
            default: ;
        endcase

        if (cmd.op == OP_FADE_SQ || cmd.op == OP_FADE_CUBE || cmd.op == OP_FADE_Q ||
            cmd.op == OP_LMUL || cmd.op == OP_ACC_MUL || cmd.op == OP_ACC_ADD) begin
            mul_reg <= mul_a * mul_b;
        end
        vq_reg      <= vld_reg[rd_addr];
        raddr_q_reg <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_WRITE) begin
                vld_reg[tidx_reg] <= 1'b1;
            end
            if (cmd.op == OP_EMIT) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.div_last = (dcnt_reg == DC_W'(TOT_W-1));
    assign sts.out_free = ~out_valid_reg | m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_data_reg};

endmodule

// ----- design/pn3o_ctrl.sv -----
// ----------------------------------------------------------------------------
// pn3o_ctrl: sequencer for the noise datapath
// Accepts items, steps the per-octave microsequence, runs the divider and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module pn3o_ctrl
    import pn3o_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tuser,
    output logic             s_tready,
    input  logic [CNT_W-1:0] octave_count,
    input  sts_t             sts,
    output cmd_t             cmd
);

    localparam int OW = $clog2(MAX_OCTAVES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_RUN,
        S_DINIT,
        S_DIV,
        S_FINISH
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic [OW-1:0]     oct_reg, n_reg;
    logic              in_fire;

    function automatic cmd_t step_cmd(input logic [STEP_W-1:0] s);
        cmd_t c;
        logic [STEP_W-1:0] r;
        logic [STEP_W-1:0] w;
        logic pp;
        logic hi;
        c.op   = OP_NOP;
        c.addr = AS_CX;
        c.sel  = AX_X;
        c.dst  = 1'b0;
        r  = '0;
        w  = '0;
        pp = 1'b0;
        hi = 1'b0;
        if (s < STEP_HASH) begin
            // four fade steps per axis
            c.sel = s[3:2];
            case (s[1:0])
                2'd0:    c.op = OP_FADE_SQ;
                2'd1:    c.op = OP_FADE_CUBE;
                2'd2:    c.op = OP_FADE_Q;
                default: c.op = OP_FADE_END;
            endcase
        end else if (s < STEP_GRAD) begin
            r      = s - STEP_HASH;
            c.addr = {1'b0, r[3:1]};
            c.op   = r[0] ? OP_CAP : OP_RD;
        end else if (s < STEP_ACC) begin
            hi = (s >= STEP_GRAD_HI);
            r  = hi ? s - STEP_GRAD_HI : s - STEP_GRAD;
            if (r < 6'd12) begin
                pp = (r >= 6'd6);
                w  = pp ? r - 6'd6 : r;
                if (w < 6'd4) begin
                    c.addr = AS_AA + {1'b0, hi, pp, w[1]};
                    c.op   = w[0] ? OP_CAP : OP_RD;
                end else begin
                    c.sel = AX_X;
                    c.dst = pp;
                    c.op  = w[0] ? OP_LADD : OP_LMUL;
                end
            end else begin
                c.sel = r[1] ? AX_Z : AX_Y;
                c.dst = hi;
                c.op  = r[0] ? OP_LADD : OP_LMUL;
            end
        end else if (s == STEP_ACC) begin
            c.op = OP_ACC_MUL;
        end else if (s == STEP_ACC_ADD) begin
            c.op = OP_ACC_ADD;
        end else begin
            c.op = OP_AMP;
        end
        return c;
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid & s_tready;

    always_comb begin
        cmd.op   = OP_NOP;
        cmd.addr = AS_CX;
        cmd.sel  = AX_X;
        cmd.dst  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.op = OP_LATCH;
                end
            end
            S_WRITE:  cmd.op = OP_WRITE;
            S_RUN:    cmd = step_cmd(step_reg);
            S_DINIT:  cmd.op = OP_DIV_INIT;
            S_DIV:    cmd.op = OP_DIV_STEP;
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.op = OP_EMIT;
                end
            end
            default:  cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            oct_reg   <= '0;
            n_reg     <= OW'(1);
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        step_reg <= '0;
                        oct_reg  <= '0;
                        if (octave_count == '0) begin
                            n_reg <= OW'(1);
                        end else if (32'(octave_count) > MAX_OCTAVES) begin
                            n_reg <= OW'(MAX_OCTAVES);
                        end else begin
                            n_reg <= OW'(octave_count);
                        end
                        state_reg <= (s_tuser == OPC_EVAL) ? S_RUN : S_WRITE;
                    end
                end
                S_WRITE: state_reg <= S_IDLE;
                S_RUN: begin
                    if (step_reg == STEP_LAST) begin
                        step_reg <= '0;
                        if (oct_reg == n_reg - 1'b1) begin
                            state_reg <= S_DINIT;
                        end else begin
                            oct_reg <= oct_reg + 1'b1;
                        end
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_DINIT: state_reg <= S_DIV;
                S_DIV: begin
                    if (sts.div_last) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (sts.out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- design/perlin_noise_3d_octaves_top.sv -----
// ----------------------------------------------------------------------------
// perlin_noise_3d_octaves_top: fractal 3D improved Perlin noise
// Sums octaves of fixed-point gradient noise, normalized by total weight.
// ----------------------------------------------------------------------------
// Table write item: latched, then written, and the next item is accepted right after.
// Evaluate item: a per-octave microsequence (one shared multiplier, one table read
// port) repeated for each of N octaves, then restoring division of the sum by the
// total weight. One item in flight.
// The result waits in an output register while the next item is taken.
// Reset: table reads as identity, octave_count = 1, persistence = 0.5.
module perlin_noise_3d_octaves_top
    import pn3o_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // table_index[7:0], table_value[15:8], pos_x[47:16], pos_y[79:48], pos_z[111:80]
    input  logic [111:0]       s_tdata,
    // opcode[0]
    input  logic               s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // noise_value[17:0]
    output logic [23:0]        m_tdata,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata
);

    logic [CNT_W-1:0] octave_count_reg;
    logic [CFG_W-1:0] persistence_reg;
    cmd_t cmd;
    sts_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            octave_count_reg <= CNT_W'(1);
            persistence_reg  <= CFG_W'(32768);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_OCTAVE_COUNT: octave_count_reg <= cfg_wdata[CNT_W-1:0];
                REG_PERSISTENCE:  persistence_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    pn3o_ctrl #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tuser      (s_tuser),
        .s_tready     (s_tready),
        .octave_count (octave_count_reg),
        .sts          (sts),
        .cmd          (cmd)
    );

    pn3o_dp #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_tdata     (s_tdata),
        .persistence (persistence_reg),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

endmodule
